// File: sv/et_pkg.sv
// Package for the Euler totient block.
// Holds the default operand width shared by the top level and its checker.
package et_pkg;

    // Default width of the value and totient fields.
    localparam int VALUE_BITS_DEF = 32;

endpackage

// File: sv/et_divider.sv
// Shared restoring divider for the Euler totient block: one quotient bit per cycle.
// Depends on nothing; the width comes from the top level.
module et_divider #(
    parameter int VALUE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [VALUE_BITS-1:0] divisor,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [VALUE_BITS-1:0] remainder
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] div_reg, div_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   diff;
    logic                  fits;

    // The partial remainder stays below the divisor, so bit VALUE_BITS of the
    // difference is set exactly when the trial subtraction borrows.
    assign trial = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = ~diff[VALUE_BITS];

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
            if (VALUE_BITS > 1) begin
                quo_next = {quo_reg[VALUE_BITS-2:0], fits};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(VALUE_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: sv/euler_totient_top.sv
// Top level of the Euler totient block: trial-division sequencer and result register.
// Depends on et_pkg and on the shared divider et_divider.
//
//   Channel   Direction  Ports                       Carries
//   s_        in         s_valid, s_ready, s_value    one request: the value n
//   m_        out        m_valid, m_ready, m_totient  one result: phi(n)
//
// Every division runs in the shared divider, one quotient bit per cycle. A request
// needs one division per odd trial divisor up to sqrt(rest), plus two per prime
// found (the answer update and the last strip attempt), one per extra power
// removed and one for a leftover prime; each factor two is stripped without a
// division.
// Reset is synchronous and active low; it clears the sequencer and m_valid.
// s_ready is high only in the idle state; a finished result waits in the
// result register while the next request is being worked on.
module euler_totient_top #(
    parameter int VALUE_BITS = et_pkg::VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [VALUE_BITS-1:0] s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_BITS-1:0] m_totient
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STRIP2,
        ST_DIV_REST,
        ST_DIV_ANS,
        ST_DIV_STRIP,
        ST_FINAL_CHK,
        ST_DIV_FINAL,
        ST_RESULT
    } state_t;

    state_t                state_reg, state_next;
    logic [VALUE_BITS-1:0] ans_reg, ans_next;
    logic [VALUE_BITS-1:0] rest_reg, rest_next;
    logic [VALUE_BITS-1:0] d_reg, d_next;
    logic                  start_reg, start_next;
    logic [VALUE_BITS-1:0] opa_reg, opa_next;
    logic [VALUE_BITS-1:0] opb_reg, opb_next;
    logic                  m_valid_reg, m_valid_next;
    logic [VALUE_BITS-1:0] m_totient_reg, m_totient_next;

    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quo;
    logic [VALUE_BITS-1:0] div_rem;
    logic [VALUE_BITS-1:0] d_plus2;
    logic [VALUE_BITS-1:0] ans_reduced;

    et_divider #(
        .VALUE_BITS(VALUE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_reg),
        .dividend (opa_reg),
        .divisor  (opb_reg),
        .done     (div_done),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    assign d_plus2 = d_reg + VALUE_BITS'(2);

    // ans / p * (p - 1) equals q * p - q, and q * p is ans minus the remainder,
    // so the update needs only subtractions.
    assign ans_reduced = ans_reg - div_rem - div_quo;

    always_comb begin
        state_next     = state_reg;
        ans_next       = ans_reg;
        rest_next      = rest_reg;
        d_next         = d_reg;
        start_next     = 1'b0;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        m_valid_next   = m_valid_reg;
        m_totient_next = m_totient_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    rest_next = s_value;
                    d_next    = VALUE_BITS'(3);
                    if (s_value == '0) begin
                        // Zero is never factored; the answer keeps its start value.
                        ans_next   = '0;
                        state_next = ST_RESULT;
                    end else if (!s_value[0]) begin
                        ans_next   = s_value >> 1;
                        state_next = ST_STRIP2;
                    end else begin
                        ans_next   = s_value;
                        start_next = 1'b1;
                        opa_next   = s_value;
                        opb_next   = VALUE_BITS'(3);
                        state_next = ST_DIV_REST;
                    end
                end
            end
            ST_STRIP2: begin
                // Remove one factor two per cycle.
                if (!rest_reg[0]) begin
                    rest_next = rest_reg >> 1;
                end else begin
                    start_next = 1'b1;
                    opa_next   = rest_reg;
                    opb_next   = d_reg;
                    state_next = ST_DIV_REST;
                end
            end
            ST_DIV_REST: begin
                // One division gives both the loop bound test and the remainder.
                if (div_done) begin
                    if (div_quo < d_reg) begin
                        state_next = ST_FINAL_CHK;
                    end else if (div_rem == '0) begin
                        rest_next  = div_quo;
                        start_next = 1'b1;
                        opa_next   = ans_reg;
                        opb_next   = d_reg;
                        state_next = ST_DIV_ANS;
                    end else begin
                        d_next     = d_plus2;
                        start_next = 1'b1;
                        opa_next   = rest_reg;
                        opb_next   = d_plus2;
                    end
                end
            end
            ST_DIV_ANS: begin
                if (div_done) begin
                    ans_next   = ans_reduced;
                    start_next = 1'b1;
                    opa_next   = rest_reg;
                    opb_next   = d_reg;
                    state_next = ST_DIV_STRIP;
                end
            end
            ST_DIV_STRIP: begin
                // Keep dividing out the prime just found.
                if (div_done) begin
                    start_next = 1'b1;
                    if (div_rem == '0) begin
                        rest_next = div_quo;
                        opa_next  = div_quo;
                        opb_next  = d_reg;
                    end else begin
                        d_next     = d_plus2;
                        opa_next   = rest_reg;
                        opb_next   = d_plus2;
                        state_next = ST_DIV_REST;
                    end
                end
            end
            ST_FINAL_CHK: begin
                // A cofactor above two left over is itself a prime.
                if (rest_reg > VALUE_BITS'(2)) begin
                    start_next = 1'b1;
                    opa_next   = ans_reg;
                    opb_next   = rest_reg;
                    state_next = ST_DIV_FINAL;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_DIV_FINAL: begin
                if (div_done) begin
                    ans_next   = ans_reduced;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_totient_next = ans_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
        ans_reg       <= ans_next;
        rest_reg      <= rest_next;
        d_reg         <= d_next;
        opa_reg       <= opa_next;
        opb_reg       <= opb_next;
        m_totient_reg <= m_totient_next;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_totient = m_totient_reg;

endmodule

// File: sv/et_checker.sv
// Port-level checker for the Euler totient block, bound to euler_totient_top.
// Depends on et_pkg for the default width.
module et_checker #(
    parameter int VALUE_BITS = et_pkg::VALUE_BITS_DEF
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic [VALUE_BITS-1:0] s_value,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [VALUE_BITS-1:0] m_totient
);

    // A waiting request holds its value.
    a_request_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_value))
        else $error("request changed while waiting");

    // A stalled result holds its value.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_totient))
        else $error("result changed while stalled");

    // An accepted request makes the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while a request was in work");

    // A new result only appears after the block was working on a request.
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a request in work");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind euler_totient_top et_checker #(
    .VALUE_BITS(VALUE_BITS)
) u_et_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_value  (s_value),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_totient(m_totient)
);

// File: test/euler_totient_top_tb.sv
// Self-checking testbench for euler_totient_top: sends values over the s_ channel
// and checks each totient on the m_ channel against a built-in trial-division predictor.
// Depends on et_pkg for the default operand width; needs nothing else but the RTL.
`timescale 1ns / 100ps

module euler_totient_top_tb;

    localparam int VB = et_pkg::VALUE_BITS_DEF;

    // Upper bound of the random wait of each side before it raises valid or ready.
    localparam int STALL_MAX = 3;

    // A 32-bit prime keeps the block busy through its whole trial loop with no handshake
    // on either side. The watchdog limit lies well above that run time.
    localparam int IDLE_LIMIT = 5_000_000;

    // A result is registered, so nothing can arrive long after the last request
    // has been answered. This short tail catches any stray extra result.
    localparam int DRAIN_CYCLES = 64;

    typedef logic [VB-1:0] word_t;

    logic  aclk      = 1'b0;
    logic  aresetn   = 1'b0;
    logic  s_valid   = 1'b0;
    logic  s_ready;
    word_t s_value   = '0;
    logic  m_valid;
    logic  m_ready   = 1'b0;
    word_t m_totient;

    // Values in flight and the totients predicted for them, oldest first.
    word_t sent_values[$];
    word_t predicted_totients[$];

    int error_count = 0;
    int idle_cycles = 0;

    // When set, both sides run back to back without any idle cycles.
    bit steady = 1'b0;

    euler_totient_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_totient (m_totient)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Totient by trial division. The answer starts at n and loses the share of
    // every distinct prime p as answer / p * (p - 1). The loop bound is written
    // as d <= rest / d so that it stays exact near the top of the range. Zero has
    // no factors at all and comes back as zero.
    function automatic word_t predict_totient(word_t n);
        bit [63:0] answer;
        bit [63:0] rest;
        bit [63:0] d;
        answer = 64'(n);
        rest = 64'(n);
        if (rest == 0) begin
            return '0;
        end
        if (rest[0] == 1'b0) begin
            answer = answer / 2;
            while (rest[0] == 1'b0) begin
                rest = rest >> 1;
            end
        end
        for (d = 3; d <= rest / d; d += 2) begin
            if (rest % d == 0) begin
                answer = answer / d * (d - 1);
                while (rest % d == 0) begin
                    rest = rest / d;
                end
            end
        end
        if (rest > 2) begin
            answer = answer / rest * (rest - 1);
        end
        return answer[VB-1:0];
    endfunction

    // A product of small factors that still fits the field. Such values reach
    // the high bits while the trial division stays short.
    function automatic word_t smooth_value();
        bit [63:0] product;
        bit [63:0] factor;
        int count;
        product = 64'd1;
        count = $urandom_range(1, 16);
        repeat (count) begin
            factor = 64'($urandom_range(2, 255));
            if (product * factor < (64'd1 << VB)) begin
                product = product * factor;
            end
        end
        return product[VB-1:0];
    endfunction

    // Sends one request and records its prediction at the edge where it is
    // accepted. s_valid is left high afterwards, so a request that follows
    // with no gap goes out without a bubble.
    task automatic send_request(input word_t value);
        int gap;
        gap = steady ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sent_values = {sent_values, value};
        predicted_totients = {predicted_totients, predict_totient(value)};
    endtask

    // The ends of the field: zero, one, two, three, all ones, all ones but bit zero, a lone top bit,
    // and alternating bit patterns so that every input bit is seen at both values.
    task automatic test_field_extremes();
        send_request(32'd1);
        send_request(32'd2);
        send_request(32'd0);
        send_request(32'd3);
        send_request(32'hFFFF_FFFF);
        send_request(32'h8000_0000);
        send_request(32'hFFFF_FFFE);
        send_request(32'hAAAA_AAAA);
        send_request(32'h5555_5555);
    endtask

    // Repeated prime factors, where each prime must be counted only once, and the plain prime 65537.
    task automatic test_prime_powers();
        send_request(32'd4);
        send_request(32'd9);
        send_request(32'd27);
        send_request(32'd63001);
        send_request(32'd3486784401);
        send_request(32'd65537);
        send_request(32'd196608);
    endtask

    // The trial loop bound: a square where the bound is met with equality, a
    // semiprime, a 20-bit prime, and the largest 32-bit prime. The last one
    // runs the divisor all the way to 65537 and dominates the run time.
    task automatic test_loop_bound();
        send_request(32'd25);
        send_request(32'd35);
        send_request(32'd1048573);
        send_request(32'd4294967291);
    endtask

    // Random 16-bit values, which keep every request short.
    task automatic test_random_small(input int count);
        for (int i = 0; i < count; i++) begin
            steady = ((i / 8) % 3) == 2;
            send_request(word_t'($urandom_range(1, 65535)));
        end
    endtask

    // A mix of small values, 20-bit values and large smooth products, in
    // stretches that alternate between random idling and back-to-back traffic.
    task automatic test_random_mixed(input int count);
        word_t value;
        for (int i = 0; i < count; i++) begin
            steady = ((i / 10) % 2) == 1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    value = $urandom_range(1, 65535);
                end
                6, 7: begin
                    value = $urandom_range(1, (1 << 20) - 1);
                end
                default: begin
                    value = smooth_value();
                end
            endcase
            send_request(value);
        end
        steady = 1'b0;
    endtask

    // Result side: waits a random number of cycles before each result, then
    // holds m_ready until a result is taken and compares it with the oldest
    // prediction. Reset must be over before m_valid is trusted.
    initial begin
        int    stall;
        word_t want;
        word_t value;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, STALL_MAX);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (predicted_totients.size() == 0) begin
                $error("totient arrived with no request waiting: actual %0d", m_totient);
                error_count++;
            end else begin
                want = predicted_totients.pop_front();
                value = sent_values.pop_front();
                if (m_totient !== want) begin
                    $error("value %0d: totient expected %0d, actual %0d",
                           value, want, m_totient);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: any cycle that moves a request or a result restarts the count.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("[euler_totient_top] ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Test sequence: reset, directed cases, random traffic, then drain.
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_field_extremes();
        test_prime_powers();
        test_loop_bound();
        test_random_small(40);
        test_random_mixed(40);

        // The last request has been accepted, so valid can drop now.
        s_valid <= 1'b0;
        while (predicted_totients.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("[euler_totient_top] OK");
        end else begin
            $display("[euler_totient_top] ERROR");
        end
        $finish;
    end

endmodule
